// ----- src/btlv_pkg.sv -----
// Shared types, codes and default sizes for the BER-TLV stream parser.
`timescale 1ns / 1ps
`default_nettype none

package btlv_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int DEF_MAX_DEPTH    = 8;
  localparam int DEF_TAG_BYTES    = 4;
  localparam int DEF_LEN_BYTES    = 4;
  localparam int DEF_BUFFER_BYTES = 65536;

  // Depth of the byte queue between the front and back parts (power of two).
  localparam int QUEUE_DEPTH = 4;

  // Width of the buffer length field on the input channel.
  localparam int TL_W = 16;

  // Low five bits of a first tag byte that announce a multi-byte tag.
  localparam logic [4:0] TAG_LOW_ALL = 5'h1F;

  // Result kinds.
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_CONTENT = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_INDEF   = 2'd1;
  localparam logic [1:0] ERR_LONG    = 2'd2;
  localparam logic [1:0] ERR_OVERRUN = 2'd3;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       tag_ext;
    logic       zero_byte;
  } btlv_item_t;

endpackage

`default_nettype wire

// ----- src/ber_tlv_stream_parser_top.sv -----
// Top level of the BER-TLV stream parser: byte queue front part and parsing back part.
//
// Usage: bytes of a BER-TLV buffer arrive on the input channel (in_valid/in_stall),
// one per transaction; first marks the opening byte of a buffer and carries its
// total_length. Results leave on the output channel (out_valid/out_stall): an element
// header record, a content byte of a primitive element, or a single error record,
// with at most one result per input byte. base_level is written through cfg_we and
// cfg_wdata only while the block is idle; the user must keep to this, as the block
// itself does not enforce it. Each byte passes the byte queue and the parsing state
// machine, and its result is held in the result register. Throughput: one byte per
// cycle unless the receiver stalls; every step, including the closing of several
// nested containers at once, is done in a single pass of the parsing state machine.
// A four-entry byte queue sits between input and parser, and a result register at the
// output, so the input keeps accepting while a result waits to be taken.
// Reset (rst, synchronous) empties the queue, returns the parser to waiting for a
// buffer and clears base_level to 0. While the receiver stalls, the result register
// holds its transaction, the parser stops, and in_stall rises once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module ber_tlv_stream_parser_top import btlv_pkg::*; #(
  parameter int MAX_DEPTH    = DEF_MAX_DEPTH,
  parameter int TAG_BYTES    = DEF_TAG_BYTES,
  parameter int LEN_BYTES    = DEF_LEN_BYTES,
  parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [7:0]      cfg_wdata,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      data_byte,
  input  wire logic            first,
  input  wire logic [TL_W-1:0] total_length,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [1:0]           kind,
  output logic [31:0]          tag_value,
  output logic [2:0]           tag_bytes,
  output logic [31:0]          content_length,
  output logic [7:0]           nest_level,
  output logic                 constructed,
  output logic                 outermost,
  output logic [7:0]           content_byte,
  output logic [1:0]           error_code
);

  localparam int BUF_W = $clog2(BUFFER_BYTES+1);

  logic             q_valid;
  btlv_item_t       q_item;
  logic [BUF_W-1:0] q_buf_len;
  logic             q_take;

  btlv_front #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .first        (first),
    .total_length (total_length),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_buf_len    (q_buf_len),
    .q_take       (q_take)
  );

  btlv_back #(
    .MAX_DEPTH    (MAX_DEPTH),
    .TAG_BYTES    (TAG_BYTES),
    .LEN_BYTES    (LEN_BYTES),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_buf_len      (q_buf_len),
    .q_take         (q_take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .tag_value      (tag_value),
    .tag_bytes      (tag_bytes),
    .content_length (content_length),
    .nest_level     (nest_level),
    .constructed    (constructed),
    .outermost      (outermost),
    .content_byte   (content_byte),
    .error_code     (error_code)
  );

endmodule

`default_nettype wire

// ----- src/btlv_front.sv -----
// Front part: accepts bytes, classifies them and queues them for the parser.
`timescale 1ns / 1ps
`default_nettype none

module btlv_front import btlv_pkg::*; #(
  parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 first,
  input  wire logic [TL_W-1:0]      total_length,
  output logic                      q_valid,
  output btlv_item_t                q_item,
  output logic [$clog2(BUFFER_BYTES+1)-1:0] q_buf_len,
  input  wire logic                 q_take
);

  localparam int BUF_W = $clog2(BUFFER_BYTES+1);
  localparam int Q_AW  = $clog2(QUEUE_DEPTH);
  localparam int Q_CW  = $clog2(QUEUE_DEPTH+1);

  btlv_item_t       item_mem [QUEUE_DEPTH];
  logic [BUF_W-1:0] len_mem  [QUEUE_DEPTH];
  logic [Q_AW-1:0]  wr_ptr;
  logic [Q_AW-1:0]  rd_ptr;
  logic [Q_CW-1:0]  count;

  btlv_item_t       item_in;
  logic [BUF_W-1:0] buf_len_in;
  logic [TL_W:0]    tl_ext;
  logic             push;

  // Classify the incoming byte and clamp the buffer length.
  always_comb begin
    item_in.data_byte = data_byte;
    item_in.first     = first;
    item_in.tag_ext   = (data_byte[4:0] == TAG_LOW_ALL);
    item_in.zero_byte = (data_byte == 8'd0);
    tl_ext            = {1'b0, total_length};
    if (tl_ext > (TL_W+1)'(BUFFER_BYTES)) begin
      buf_len_in = BUF_W'(BUFFER_BYTES);
    end else begin
      buf_len_in = BUF_W'(tl_ext);
    end
  end

  assign in_stall  = (count == Q_CW'(QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign q_valid   = (count != '0);
  assign q_item    = item_mem[rd_ptr];
  assign q_buf_len = len_mem[rd_ptr];

  // Queue pointers and storage.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        item_mem[wr_ptr] <= item_in;
        len_mem[wr_ptr]  <= buf_len_in;
        wr_ptr           <= wr_ptr + 1'b1;
      end
      if (q_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // The queue never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CW'(QUEUE_DEPTH))
    else $error("queue count exceeds its depth");

  // The parser only takes a byte that is present.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_take |-> (count != '0))
    else $error("parser took a byte from an empty queue");

endmodule

`default_nettype wire

// ----- src/btlv_back.sv -----
// Back part: BER-TLV parsing state machine, container stack and result register.
`timescale 1ns / 1ps
`default_nettype none

module btlv_back import btlv_pkg::*; #(
  parameter int MAX_DEPTH    = DEF_MAX_DEPTH,
  parameter int TAG_BYTES    = DEF_TAG_BYTES,
  parameter int LEN_BYTES    = DEF_LEN_BYTES,
  parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [7:0]           cfg_wdata,
  input  wire logic                 q_valid,
  input  wire btlv_item_t           q_item,
  input  wire logic [$clog2(BUFFER_BYTES+1)-1:0] q_buf_len,
  output logic                      q_take,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                kind,
  output logic [31:0]               tag_value,
  output logic [2:0]                tag_bytes,
  output logic [31:0]               content_length,
  output logic [7:0]                nest_level,
  output logic                      constructed,
  output logic                      outermost,
  output logic [7:0]                content_byte,
  output logic [1:0]                error_code
);

  localparam int BUF_W = $clog2(BUFFER_BYTES+1);
  localparam int DEP_W = $clog2(MAX_DEPTH+1);
  localparam int IDX_W = $clog2(MAX_DEPTH);
  localparam int CNT_W = $clog2(TAG_BYTES+1);
  localparam int LL_W  = $clog2(LEN_BYTES+1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TAG_MORE,
    PH_LEN_FIRST,
    PH_LEN_MORE,
    PH_CONTENT,
    PH_SKIP_LEN,
    PH_DONE
  } phase_t;

  // Parser state.
  phase_t           phase, phase_next;
  logic [31:0]      tag_shift, tag_shift_next;
  logic [CNT_W-1:0] tag_count, tag_count_next;
  logic [31:0]      length_accum, length_accum_next;
  logic [LL_W-1:0]  len_left, len_left_next;
  logic [DEP_W-1:0] depth, depth_next;
  logic [BUF_W-1:0] buf_rem, buf_rem_next;
  logic [31:0]      content_rem, content_rem_next;
  logic             err_latched, err_latched_next;
  logic             lead_cons, lead_cons_next;
  logic [7:0]       base_level;

  // Bytes left in each open container, with a zero flag per entry.
  logic [31:0]          stack [MAX_DEPTH];
  logic [MAX_DEPTH-1:0] zflag;

  // Values as seen by the current byte (a first byte clears the parser).
  logic [7:0]       b;
  logic             adv;
  phase_t           ph_e;
  logic [DEP_W-1:0] dep_e;
  logic             err_e;
  logic [BUF_W-1:0] buf_e;
  logic [IDX_W-1:0] top_idx;
  logic [IDX_W-1:0] push_idx;
  logic [31:0]      top;
  logic             in_container;
  logic             take_fail;
  logic [6:0]       n_len;
  logic [31:0]      fin_len;
  logic             room_over;
  logic [31:0]      top_sub;
  logic             depth_full;
  logic [9:0]       level_sum;
  logic [7:0]       level;
  logic [DEP_W-1:0] below_depth;

  // Stack write controls and the next result.
  logic        top_we;
  logic [31:0] top_wdata;
  logic        push_we;
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [31:0] res_tag;
  logic [2:0]  res_tag_bytes;
  logic [31:0] res_len;
  logic [7:0]  res_level;
  logic        res_cons;
  logic        res_outer;
  logic [7:0]  res_byte;
  logic [1:0]  res_err;

  assign b      = q_item.data_byte;
  assign adv    = q_valid && (!out_valid || !out_stall);
  assign q_take = adv;

  // Effective state, container top and the header checks shared by all phases.
  always_comb begin
    ph_e         = q_item.first ? PH_IDLE : phase;
    dep_e        = q_item.first ? '0 : depth;
    err_e        = q_item.first ? 1'b0 : err_latched;
    buf_e        = q_item.first ? q_buf_len : buf_rem;
    top_idx      = IDX_W'(dep_e - 1'b1);
    push_idx     = dep_e[IDX_W-1:0];
    top          = stack[top_idx];
    in_container = (dep_e != '0);
    take_fail    = in_container && (top == 32'd0);
    n_len        = b[6:0];
    if (ph_e == PH_LEN_MORE) begin
      fin_len = {length_accum[23:0], b};
    end else if (b[7]) begin
      fin_len = 32'd0;
    end else begin
      fin_len = {24'd0, b};
    end
    // The header byte is already counted, so room is one less than stored.
    if (in_container) begin
      room_over = (fin_len >= top);
    end else begin
      room_over = (fin_len >= 32'(buf_e));
    end
    top_sub    = top + ~fin_len;
    depth_full = (dep_e >= DEP_W'(MAX_DEPTH));
    level_sum  = 10'(base_level) + 10'd1 + 10'(dep_e);
    level      = (level_sum > 10'd255) ? 8'hFF : level_sum[7:0];
  end

  // Deepest enclosing container below the top that still has bytes left.
  always_comb begin
    below_depth = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if ((DEP_W'(i + 1) < dep_e) && !zflag[i]) begin
        below_depth = DEP_W'(i + 1);
      end
    end
  end

  // Per-byte parsing step.
  always_comb begin
    logic             do_finish;
    logic             do_unwind;
    logic             unw_top_zero;
    logic             do_error;
    logic [1:0]       err_sel;
    logic [DEP_W-1:0] unw_dep;

    do_finish    = 1'b0;
    do_unwind    = 1'b0;
    unw_top_zero = 1'b0;
    do_error     = 1'b0;
    err_sel      = ERR_NONE;
    unw_dep      = dep_e;

    phase_next        = phase;
    tag_shift_next    = tag_shift;
    tag_count_next    = tag_count;
    length_accum_next = length_accum;
    len_left_next     = len_left;
    depth_next        = depth;
    buf_rem_next      = buf_rem;
    content_rem_next  = content_rem;
    err_latched_next  = err_latched;
    lead_cons_next    = lead_cons;

    top_we    = 1'b0;
    top_wdata = top - 1'b1;
    push_we   = 1'b0;

    res_valid     = 1'b0;
    res_kind      = KIND_HEADER;
    res_tag       = 32'd0;
    res_tag_bytes = 3'd0;
    res_len       = 32'd0;
    res_level     = 8'd0;
    res_cons      = 1'b0;
    res_outer     = 1'b0;
    res_byte      = 8'd0;
    res_err       = ERR_NONE;

    if (adv) begin
      if (q_item.first) begin
        phase_next       = PH_IDLE;
        depth_next       = '0;
        err_latched_next = 1'b0;
        buf_rem_next     = buf_e;
      end
      if (!err_e && (buf_e != '0) && (ph_e != PH_DONE)) begin
        buf_rem_next = buf_e - 1'b1;
        case (ph_e)
          PH_IDLE: begin
            if (in_container && (top < 32'd2)) begin
              // Short tail: the container closes.
              top_we       = 1'b1;
              top_wdata    = 32'd0;
              do_unwind    = 1'b1;
              unw_top_zero = 1'b1;
            end else begin
              top_we            = in_container;
              lead_cons_next    = b[5];
              tag_shift_next    = {24'd0, b};
              tag_count_next    = CNT_W'(1);
              length_accum_next = 32'd0;
              if (in_container && q_item.zero_byte) begin
                phase_next = PH_SKIP_LEN;
              end else if (q_item.tag_ext) begin
                phase_next = PH_TAG_MORE;
              end else begin
                phase_next = PH_LEN_FIRST;
              end
            end
          end
          PH_TAG_MORE: begin
            if (take_fail) begin
              do_error = 1'b1;
              err_sel  = ERR_OVERRUN;
            end else if (tag_count >= CNT_W'(TAG_BYTES)) begin
              do_error = 1'b1;
              err_sel  = ERR_LONG;
            end else begin
              top_we         = in_container;
              tag_shift_next = {tag_shift[23:0], b};
              tag_count_next = tag_count + 1'b1;
              if (!b[7]) begin
                phase_next = PH_LEN_FIRST;
              end
            end
          end
          PH_LEN_FIRST: begin
            if (take_fail) begin
              do_error = 1'b1;
              err_sel  = ERR_OVERRUN;
            end else if (b[7] && !in_container && (n_len == 7'd0)) begin
              do_error = 1'b1;
              err_sel  = ERR_INDEF;
            end else if (b[7] && (n_len > 7'(LEN_BYTES))) begin
              do_error = 1'b1;
              err_sel  = ERR_LONG;
            end else begin
              top_we            = in_container;
              length_accum_next = fin_len;
              if (b[7] && (n_len != 7'd0)) begin
                len_left_next = LL_W'(n_len);
                phase_next    = PH_LEN_MORE;
              end else begin
                do_finish = 1'b1;
              end
            end
          end
          PH_LEN_MORE: begin
            if (take_fail) begin
              do_error = 1'b1;
              err_sel  = ERR_OVERRUN;
            end else begin
              top_we            = in_container;
              length_accum_next = fin_len;
              len_left_next     = len_left - 1'b1;
              if (len_left == LL_W'(1)) begin
                do_finish = 1'b1;
              end
            end
          end
          PH_CONTENT: begin
            res_valid        = 1'b1;
            res_kind         = KIND_CONTENT;
            res_byte         = b;
            content_rem_next = content_rem - 1'b1;
            if (content_rem == 32'd1) begin
              if (!in_container) begin
                phase_next = PH_DONE;
              end else begin
                do_unwind    = 1'b1;
                unw_top_zero = zflag[top_idx];
              end
            end
          end
          PH_SKIP_LEN: begin
            if (take_fail) begin
              do_error = 1'b1;
              err_sel  = ERR_OVERRUN;
            end else begin
              top_we       = 1'b1;
              do_unwind    = 1'b1;
              unw_top_zero = (top == 32'd1);
            end
          end
          default: begin
            phase_next = PH_DONE;
          end
        endcase

        // Complete header: check room and depth, emit the record.
        if (do_finish) begin
          if (room_over || (lead_cons && (fin_len != 32'd0) && depth_full)) begin
            do_error = 1'b1;
            err_sel  = ERR_OVERRUN;
          end else begin
            res_valid     = 1'b1;
            res_kind      = KIND_HEADER;
            res_tag       = tag_shift;
            res_tag_bytes = (int'(tag_count) > 7) ? 3'd7 : 3'(tag_count);
            res_len       = fin_len;
            res_level     = level;
            res_cons      = lead_cons;
            res_outer     = !in_container;
            if (in_container) begin
              top_we    = 1'b1;
              top_wdata = top_sub;
            end
            if (fin_len == 32'd0) begin
              if (!in_container) begin
                phase_next = PH_DONE;
              end else begin
                do_unwind    = 1'b1;
                unw_top_zero = (top == 32'd1);
              end
            end else if (lead_cons) begin
              push_we    = 1'b1;
              depth_next = dep_e + 1'b1;
              phase_next = PH_IDLE;
            end else begin
              content_rem_next = fin_len;
              phase_next       = PH_CONTENT;
            end
          end
        end

        if (do_error) begin
          res_valid        = 1'b1;
          res_kind         = KIND_ERROR;
          res_err          = err_sel;
          err_latched_next = 1'b1;
          top_we           = 1'b0;
          push_we          = 1'b0;
          do_unwind        = 1'b0;
        end

        // Close every exhausted container; the buffer ends with the last one.
        if (do_unwind) begin
          unw_dep    = unw_top_zero ? below_depth : dep_e;
          depth_next = unw_dep;
          phase_next = (unw_dep == '0) ? PH_DONE : PH_IDLE;
        end
      end
    end
  end

  // State, stack and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tag_shift    <= 32'd0;
      tag_count    <= '0;
      length_accum <= 32'd0;
      len_left     <= '0;
      depth        <= '0;
      buf_rem      <= '0;
      content_rem  <= 32'd0;
      err_latched  <= 1'b0;
      lead_cons    <= 1'b0;
      base_level   <= 8'd0;
      zflag        <= '0;
      out_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      tag_shift    <= tag_shift_next;
      tag_count    <= tag_count_next;
      length_accum <= length_accum_next;
      len_left     <= len_left_next;
      depth        <= depth_next;
      buf_rem      <= buf_rem_next;
      content_rem  <= content_rem_next;
      err_latched  <= err_latched_next;
      lead_cons    <= lead_cons_next;
      if (cfg_we) begin
        base_level <= cfg_wdata;
      end
      if (top_we) begin
        stack[top_idx] <= top_wdata;
        zflag[top_idx] <= (top_wdata == 32'd0);
      end
      if (push_we) begin
        stack[push_idx] <= fin_len;
        zflag[push_idx] <= 1'b0;
      end
      if (adv) begin
        out_valid <= res_valid;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (adv && res_valid) begin
        kind           <= res_kind;
        tag_value      <= res_tag;
        tag_bytes      <= res_tag_bytes;
        content_length <= res_len;
        nest_level     <= res_level;
        constructed    <= res_cons;
        outermost      <= res_outer;
        content_byte   <= res_byte;
        error_code     <= res_err;
      end
    end
  end

  // The stack never holds more open containers than it has entries.
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEP_W'(MAX_DEPTH))
    else $error("container depth exceeds the stack size");

  // A finished buffer has no open container left.
  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |-> (depth == '0))
    else $error("buffer finished with containers still open");

  // Content bytes are only expected while some remain.
  a_content_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CONTENT) |-> (content_rem != 32'd0))
    else $error("content phase with no bytes remaining");

endmodule

`default_nettype wire

// ----- tb/ber_tlv_stream_parser_top_test.sv -----
// Self-checking testbench for the BER-TLV stream parser top level.
`timescale 1ns / 1ps

module ber_tlv_stream_parser_top_test;
  import btlv_pkg::*;

  localparam int HOLD_CYCLES   = 150;
  localparam int SETTLE_CYCLES = 12;
  localparam int STUCK_LIMIT   = 4000;

  typedef logic [7:0] byte_q_t[$];

  // One result record as it leaves the block.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tag_value;
    logic [2:0]  tag_bytes;
    logic [31:0] content_length;
    logic [7:0]  nest_level;
    logic        constructed;
    logic        outermost;
    logic [7:0]  content_byte;
    logic [1:0]  error_code;
  } tlv_rec_t;

  // Decoder states of the predictor.
  typedef enum logic [2:0] {
    P_WAIT_TAG, P_TAG_EXT, P_LEN_HEAD, P_LEN_EXT, P_BODY, P_ZERO_LEN, P_END
  } parse_state_e;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [7:0]           cfg_wdata = 8'd0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           data_byte = 8'd0;
  logic                 first = 1'b0;
  logic [TL_W-1:0]      total_length = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           kind;
  logic [31:0]          tag_value;
  logic [2:0]           tag_bytes;
  logic [31:0]          content_length;
  logic [7:0]           nest_level;
  logic                 constructed;
  logic                 outermost;
  logic [7:0]           content_byte;
  logic [1:0]           error_code;

  ber_tlv_stream_parser_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
    .first(first), .total_length(total_length),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .tag_value(tag_value), .tag_bytes(tag_bytes), .content_length(content_length),
    .nest_level(nest_level), .constructed(constructed), .outermost(outermost),
    .content_byte(content_byte), .error_code(error_code)
  );

  always #6 clk = ~clk;

  // Predictor state: a private copy of the decoder and of base_level.
  logic [7:0]   base_lvl = 8'd0;
  parse_state_e ph = P_WAIT_TAG;
  logic [31:0]  tag_acc = '0;
  int           tag_cnt = 0;
  logic [31:0]  len_acc = '0;
  int           len_left = 0;
  logic [31:0]  room_left [DEF_MAX_DEPTH];
  int           depth = 0;
  int unsigned  buf_left = 0;
  logic [31:0]  body_left = '0;
  bit           halted = 1'b0;
  logic [7:0]   lead_byte = 8'd0;

  tlv_rec_t pending_records[$];
  int       mismatches = 0;
  int       stuck_cycles = 0;
  int       in_idle_pct = 17;
  int       out_idle_pct = 48;
  int       hold_ask = 0;
  int       hold_seen = 0;
  int       hold_left = 0;

  // Error record; the rest of the buffer is dropped afterwards.
  function automatic bit raise_error(input logic [1:0] code, output tlv_rec_t rec);
    rec = '0;
    rec.kind = KIND_ERROR;
    rec.error_code = code;
    halted = 1'b1;
    return 1'b1;
  endfunction

  // A header byte is charged to the innermost open container, if any.
  function automatic bit take_header_byte();
    if (depth == 0) return 1'b1;
    if (room_left[depth-1] == 0) return 1'b0;
    room_left[depth-1]--;
    return 1'b1;
  endfunction

  // Pop every exhausted container; the buffer is done when none is left.
  function automatic void close_done();
    ph = P_WAIT_TAG;
    while (depth > 0 && room_left[depth-1] == 0) depth--;
    if (depth == 0) ph = P_END;
  endfunction

  function automatic void end_elem();
    if (depth == 0) ph = P_END;
    else close_done();
  endfunction

  // Checks the decoded length against its container and opens the element.
  function automatic bit finish_header(output tlv_rec_t rec);
    int unsigned avail;
    int unsigned lvl;
    bit cons;
    cons = lead_byte[5];
    avail = (depth == 0) ? buf_left : room_left[depth-1];
    if (len_acc > avail) return raise_error(ERR_OVERRUN, rec);
    if (cons && len_acc != 0 && depth >= DEF_MAX_DEPTH) return raise_error(ERR_OVERRUN, rec);
    lvl = base_lvl + 1 + depth;
    if (lvl > 255) lvl = 255;
    rec = '0;
    rec.kind = KIND_HEADER;
    rec.tag_value = tag_acc;
    rec.tag_bytes = (tag_cnt > 7) ? 3'd7 : 3'(tag_cnt);
    rec.content_length = len_acc;
    rec.nest_level = lvl[7:0];
    rec.constructed = cons;
    rec.outermost = (depth == 0);
    if (depth > 0) room_left[depth-1] -= len_acc;
    if (len_acc == 0) begin
      end_elem();
    end else if (cons) begin
      room_left[depth] = len_acc;
      depth++;
      ph = P_WAIT_TAG;
    end else begin
      body_left = len_acc;
      ph = P_BODY;
    end
    return 1'b1;
  endfunction

  // Advances the predictor by one accepted byte; returns 1 with a record when one is due.
  function automatic bit decode_byte(input logic [7:0] b, input logic fst,
                                     input logic [15:0] tl, output tlv_rec_t rec);
    rec = '0;
    if (fst) begin
      ph = P_WAIT_TAG;
      tag_acc = '0;
      tag_cnt = 0;
      len_acc = '0;
      len_left = 0;
      foreach (room_left[i]) room_left[i] = '0;
      depth = 0;
      body_left = '0;
      halted = 1'b0;
      lead_byte = 8'd0;
      buf_left = tl;
    end
    if (halted || buf_left == 0 || ph == P_END) return 1'b0;
    buf_left--;
    case (ph)
      P_WAIT_TAG: begin
        if (depth > 0) begin
          // A lone trailing byte cannot start an element and closes the container.
          if (room_left[depth-1] < 2) begin
            room_left[depth-1] = '0;
            close_done();
            return 1'b0;
          end
          room_left[depth-1]--;
        end
        lead_byte = b;
        tag_acc = {24'd0, b};
        tag_cnt = 1;
        len_acc = '0;
        if (depth > 0 && b == 8'h00) ph = P_ZERO_LEN;
        else if (b[4:0] == TAG_LOW_ALL) ph = P_TAG_EXT;
        else ph = P_LEN_HEAD;
        return 1'b0;
      end
      P_TAG_EXT: begin
        if (!take_header_byte()) return raise_error(ERR_OVERRUN, rec);
        if (tag_cnt >= DEF_TAG_BYTES) return raise_error(ERR_LONG, rec);
        tag_acc = {tag_acc[23:0], b};
        tag_cnt++;
        if (!b[7]) ph = P_LEN_HEAD;
        return 1'b0;
      end
      P_LEN_HEAD: begin
        if (!take_header_byte()) return raise_error(ERR_OVERRUN, rec);
        if (b[7]) begin
          if (depth == 0 && b[6:0] == 0) return raise_error(ERR_INDEF, rec);
          if (b[6:0] > DEF_LEN_BYTES) return raise_error(ERR_LONG, rec);
          len_acc = '0;
          if (b[6:0] == 0) return finish_header(rec);
          len_left = b[6:0];
          ph = P_LEN_EXT;
          return 1'b0;
        end
        len_acc = {24'd0, b};
        return finish_header(rec);
      end
      P_LEN_EXT: begin
        if (!take_header_byte()) return raise_error(ERR_OVERRUN, rec);
        len_acc = {len_acc[23:0], b};
        if (len_left > 0) len_left--;
        if (len_left == 0) return finish_header(rec);
        return 1'b0;
      end
      P_BODY: begin
        rec.kind = KIND_CONTENT;
        rec.content_byte = b;
        if (body_left > 0) body_left--;
        if (body_left == 0) end_elem();
        return 1'b1;
      end
      P_ZERO_LEN: begin
        if (!take_header_byte()) return raise_error(ERR_OVERRUN, rec);
        close_done();
        return 1'b0;
      end
      default: begin
        ph = P_END;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void check_field(string fname, logic [31:0] got_v, logic [31:0] want_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, fname, want_v, got_v);
    end
  endfunction

  // Sample both channels at each edge: check results, predict accepted bytes.
  always @(posedge clk) begin : monitor
    tlv_rec_t want;
    tlv_rec_t got;
    bit       any_xfer;
    any_xfer = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        any_xfer = 1'b1;
        if (pending_records.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result transaction, kind %0d", $time, kind);
        end else begin
          want = pending_records.pop_front();
          got.kind = kind;
          got.tag_value = tag_value;
          got.tag_bytes = tag_bytes;
          got.content_length = content_length;
          got.nest_level = nest_level;
          got.constructed = constructed;
          got.outermost = outermost;
          got.content_byte = content_byte;
          got.error_code = error_code;
          check_field("kind", got.kind, want.kind);
          check_field("tag_value", got.tag_value, want.tag_value);
          check_field("tag_bytes", got.tag_bytes, want.tag_bytes);
          check_field("content_length", got.content_length, want.content_length);
          check_field("nest_level", got.nest_level, want.nest_level);
          check_field("constructed", got.constructed, want.constructed);
          check_field("outermost", got.outermost, want.outermost);
          check_field("content_byte", got.content_byte, want.content_byte);
          check_field("error_code", got.error_code, want.error_code);
        end
      end
      if (in_valid && !in_stall) begin
        any_xfer = 1'b1;
        if (decode_byte(data_byte, first, total_length, want)) pending_records.push_back(want);
      end
      stuck_cycles = any_xfer ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Receiver: random stalls, or one long hold-off when asked for.
  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < out_idle_pct);
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Offers one byte, with random idle cycles ahead, and waits for the transaction.
  task automatic send_byte(input logic [7:0] b, input logic fst, input logic [15:0] tl);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    first <= fst;
    total_length <= tl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_buffer(input byte_q_t q, input logic [15:0] tl);
    foreach (q[i]) send_byte(q[i], i == 0, (i == 0) ? tl : 16'($urandom_range(0, 65535)));
  endtask

  // Stop sending until every expected record is out and the byte queue has drained.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_base(input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    base_lvl = v;
  endtask

  // Tag bytes: mostly one byte, sometimes a multi-byte tag, rarely one too long.
  function automatic byte_q_t make_tag(bit cons, bit inner);
    byte_q_t q;
    logic [7:0] b;
    int extra;
    b = rand_byte();
    b[5] = cons;
    if ($urandom_range(0, 3) == 0) begin
      b[4:0] = TAG_LOW_ALL;
      q.push_back(b);
      extra = ($urandom_range(0, 49) == 0) ? 4 : $urandom_range(1, 3);
      for (int i = 0; i < extra; i++) begin
        b = rand_byte();
        b[7] = (i != extra - 1);
        q.push_back(b);
      end
    end else begin
      if (b[4:0] == TAG_LOW_ALL) b[4] = 1'b0;
      if (inner && b == 8'h00) b = 8'h01;
      q.push_back(b);
    end
    return q;
  endfunction

  // Length field in short form, long form with padding, or the inner zero form.
  function automatic byte_q_t enc_len(int unsigned n, bit inner);
    byte_q_t q;
    int nb;
    if (inner && n == 0 && $urandom_range(0, 3) == 0) begin
      q.push_back(8'h80);
      return q;
    end
    if (n < 128 && $urandom_range(0, 3) != 0) begin
      q.push_back(n[7:0]);
      return q;
    end
    nb = (n > 255) ? 2 : 1;
    nb = $urandom_range(nb, DEF_LEN_BYTES);
    q.push_back(8'h80 | 8'(nb));
    for (int i = nb - 1; i >= 0; i--) q.push_back(8'(n >> (8 * i)));
    return q;
  endfunction

  // Well-formed element; chain forces that many nested containers.
  function automatic byte_q_t make_elem(int lvl, int chain);
    byte_q_t body;
    byte_q_t res;
    bit cons;
    int kids;
    cons = (chain > 0) || (lvl < 3 && $urandom_range(0, 2) == 0);
    if (cons) begin
      kids = (chain > 0) ? 1 : $urandom_range(0, 3);
      for (int k = 0; k < kids; k++)
        body = {body, make_elem(lvl + 1, (chain > 0) ? chain - 1 : 0)};
      // Zero tag pair and a lone trailing byte are both legal filler.
      if ($urandom_range(0, 4) == 0) body = {body, 8'h00, rand_byte()};
      if ($urandom_range(0, 4) == 0) body.push_back(rand_byte());
    end else if ($urandom_range(0, 29) == 0) begin
      repeat ($urandom_range(120, 260)) body.push_back(rand_byte());
    end else begin
      repeat ($urandom_range(0, 6)) body.push_back(rand_byte());
    end
    res = {make_tag(cons, lvl > 0), enc_len(body.size(), lvl > 0), body};
    return res;
  endfunction

  // Bytes with no buffer open, an empty buffer, and bytes past the outer element.
  task automatic test_no_buffer();
    byte_q_t q;
    send_byte(8'h30, 1'b0, 16'hFFFF);
    send_byte(8'h00, 1'b0, 16'h0000);
    q = {8'h04, 8'h01, 8'h7E};
    send_buffer(q, 16'd0);
    q = {8'h04, 8'h00, 8'h11, 8'h22};
    send_buffer(q, 16'd10);
  endtask

  // Primitive elements, the longest tag and the longest length field.
  task automatic test_primitive_forms();
    byte_q_t q;
    q = {8'h04, 8'h02, 8'hAA, 8'h55};
    send_buffer(q, 16'd4);
    q = {8'hDF, 8'hFF, 8'hFF, 8'h7F, 8'h00};
    send_buffer(q, 16'd5);
    q = {8'h3F, 8'h81, 8'h01, 8'h00};
    send_buffer(q, 16'hFFFF);
    q = {8'h04, 8'h84, 8'h00, 8'h00, 8'h00, 8'h02, 8'hAB, 8'hCD};
    send_buffer(q, 16'd8);
    q = {8'hFF, 8'h7F, 8'h01, 8'h00};
    send_buffer(q, 16'd4);
  endtask

  // Every error code, and bytes after an error being dropped.
  task automatic test_error_cases();
    byte_q_t q;
    q = {8'h30, 8'h80, 8'h04, 8'h00};
    send_buffer(q, 16'd4);
    q = {8'h1F, 8'h81, 8'h82, 8'h83, 8'h84, 8'h01};
    send_buffer(q, 16'd6);
    q = {8'h04, 8'h85, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
    send_buffer(q, 16'd7);
    q = {8'h04, 8'h05, 8'h11, 8'h22};
    send_buffer(q, 16'd4);
    q = {8'h30, 8'h03, 8'h1F, 8'h81, 8'h81, 8'h01};
    send_buffer(q, 16'd6);
    q = {8'h30, 8'h03, 8'h04, 8'h05, 8'h00};
    send_buffer(q, 16'd5);
    q = {8'h30, 8'h04, 8'h04, 8'h84, 8'h00, 8'h00, 8'h00, 8'h01};
    send_buffer(q, 16'd8);
  endtask

  // Inner zero-length form, zero tag skip, short tail and plain nesting.
  task automatic test_nested_special();
    byte_q_t q;
    q = {8'h30, 8'h07, 8'h04, 8'h80, 8'h00, 8'h99, 8'h05, 8'h00, 8'h77};
    send_buffer(q, 16'd9);
    q = {8'h30, 8'h06, 8'hA1, 8'h04, 8'h02, 8'h02, 8'h01, 8'hFF};
    send_buffer(q, 16'd8);
    q = {8'h30, 8'h05, 8'h04, 8'h82, 8'h00, 8'h01, 8'h5A};
    send_buffer(q, 16'd7);
  endtask

  // Eight nested containers pass, nine trip the depth limit.
  task automatic test_depth_limit();
    byte_q_t q;
    for (int n = DEF_MAX_DEPTH; n <= DEF_MAX_DEPTH + 1; n++) begin
      q = {8'h04, 8'h01, 8'h5A};
      for (int lv = 0; lv < n; lv++) q = {8'h30, 8'(q.size()), q};
      send_buffer(q, 16'(q.size()));
    end
  endtask

  // Long receiver hold-off while bytes keep coming, then a full drain pause.
  task automatic test_backpressure();
    byte_q_t q;
    hold_ask <= hold_ask + 1;
    q = {8'h04, 8'h81, 8'd40};
    repeat (40) q.push_back(rand_byte());
    send_buffer(q, 16'(q.size()));
    wait_idle();
    q = {8'h30, 8'h03, 8'h02, 8'h01, 8'h7F};
    send_buffer(q, 16'(q.size()));
  endtask

  // Random buffers: mostly well formed, some corrupted, truncated or pure noise.
  task automatic test_random(input int items, input int in_pct, input int out_pct,
                             input logic [7:0] base);
    byte_q_t q;
    logic [15:0] tl;
    int sent;
    int r;
    sent = 0;
    wait_idle();
    set_base(base);
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    while (sent < items) begin
      r = $urandom_range(0, 99);
      q = make_elem(0, (r < 5) ? $urandom_range(DEF_MAX_DEPTH - 1, DEF_MAX_DEPTH + 1) : 0);
      tl = 16'(q.size());
      if (r < 10) begin
        tl = 16'hFFFF;
      end else if (r >= 70 && r < 84) begin
        q[$urandom_range(0, q.size() - 1)] = rand_byte();
      end else if (r >= 84 && r < 92) begin
        tl = 16'($urandom_range(0, q.size() - 1));
      end else if (r >= 92) begin
        q.delete();
        repeat ($urandom_range(1, 10)) q.push_back(rand_byte());
        tl = ($urandom_range(0, 1) == 0) ? 16'(q.size()) : 16'($urandom_range(0, 65535));
      end
      send_buffer(q, tl);
      sent += q.size();
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, 3)) send_byte(rand_byte(), 1'b0, 16'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_base(8'd250);
    test_no_buffer();
    test_primitive_forms();
    test_error_cases();
    test_nested_special();
    test_depth_limit();
    test_backpressure();
    test_random(330, 17, 48, 8'd0);
    test_random(330, 48, 17, 8'd255);
    test_random(330, 0, 0, 8'($urandom_range(1, 254)));
    wait_idle();
    if (mismatches == 0 && pending_records.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- sim.f -----
src/btlv_pkg.sv
src/btlv_front.sv
src/btlv_back.sv
src/ber_tlv_stream_parser_top.sv
tb/ber_tlv_stream_parser_top_test.sv
